>>> hw/rtl/stepper_step_count_controller_unit_defines.svh
// Assertion macros shared by the checker of the step count controller.
`ifndef STEPPER_STEP_COUNT_CONTROLLER_UNIT_DEFINES_SVH
`define STEPPER_STEP_COUNT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SSCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step count controller check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SSCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step count controller check failed");

`endif

>>> hw/rtl/sscc_pkg.sv
// Types and constants shared by the step count controller files.
`default_nettype none

package sscc_pkg;

  // Input word of one request.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] amount;
    logic        limit_ok;
  } sscc_in_t;

  // Result word reported for every request.
  typedef struct packed {
    logic [31:0] accepted_steps;
    logic [15:0] timer_period;
    logic [14:0] timer_compare;
    logic        pulse_enable;
    logic        activity_lamp;
    logic [1:0]  motion_status;
    logic [31:0] steps_done;
    logic [31:0] steps_wanted;
  } sscc_out_t;

  // Operation of the shared iterative unit.
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } sscc_op_e;

  // Command to the iterative unit.
  typedef struct packed {
    logic     start;
    sscc_op_e op;
  } sscc_cmd_t;

  // Status of the iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sscc_sts_t;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRV_RESET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR       = 3'd6;

  // Request types.
  localparam logic [1:0] REQ_STEPS = 2'd0;
  localparam logic [1:0] REQ_DIST  = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;

  // Motion status code when the motor stands still.
  localparam logic [1:0] MOTION_STOP = 2'd2;

  // Highest microstep mode with a meaning (sixteenth step).
  localparam logic [2:0] MODE_MAX = 3'd4;

  // Register reset values.
  localparam logic [19:0] FREQ_RESET = 20'd1000;
  localparam logic [31:0] SPD_RESET  = 32'd200;

  // Number of steps of a 32 by 32 bit shift-add multiply.
  localparam logic [5:0] MUL_STEPS = 6'd32;

endpackage

`default_nettype wire

>>> hw/rtl/sscc_iter_unit.sv
// Shared iterative unit: shift-add multiplier and restoring divider on one adder.
`default_nettype none

module sscc_iter_unit #(
  parameter int DIV_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sscc_pkg::sscc_cmd_t cmd_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  output sscc_pkg::sscc_sts_t    sts_o,
  output logic [63:0]            result_o
);

  // Dividend is aligned so that its top bit sits at bit 31.
  localparam int ALIGN = 32 - DIV_W;

  logic [31:0]        hi_q, hi_d;
  logic [31:0]        lo_q, lo_d;
  logic [31:0]        b_q;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  sscc_pkg::sscc_op_e op_q, op_d;

  logic [32:0] add_x;
  logic [32:0] add_y;
  logic        add_cin;
  logic [33:0] add_sum;
  logic [32:0] rem_sh;

  // The one adder: adds the multiplicand or subtracts the divisor.
  always_comb begin
    rem_sh = {hi_q, lo_q[31]};
    if (op_q == sscc_pkg::OP_MUL) begin
      add_x   = {1'b0, hi_q};
      add_y   = lo_q[0] ? {1'b0, b_q} : 33'd0;
      add_cin = 1'b0;
    end else begin
      add_x   = rem_sh;
      add_y   = ~{1'b0, b_q};
      add_cin = 1'b1;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {33'd0, add_cin};
  end

  // Next state of the datapath and the step counter.
  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      op_d   = cmd_i.op;
      hi_d   = 32'd0;
      busy_d = 1'b1;
      if (cmd_i.op == sscc_pkg::OP_MUL) begin
        lo_d  = a_i;
        cnt_d = sscc_pkg::MUL_STEPS;
      end else begin
        lo_d  = a_i << ALIGN;
        cnt_d = 6'(DIV_W);
      end
    end else if (busy_q) begin
      if (op_q == sscc_pkg::OP_MUL) begin
        hi_d = add_sum[32:1];
        lo_d = {add_sum[0], lo_q[31:1]};
      end else if (add_sum[33]) begin
        hi_d = add_sum[31:0];
        lo_d = {lo_q[30:0], 1'b1};
      end else begin
        hi_d = rem_sh[31:0];
        lo_d = {lo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= sscc_pkg::OP_MUL;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (cmd_i.start) begin
      b_q <= b_i;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = {hi_q, lo_q};

endmodule

`default_nettype wire

>>> hw/rtl/stepper_step_count_controller_unit.sv
// A request passes from S_IDLE through S_DEC to S_FIN. A move goes by S_MOVE; a move by
// distance in a valid microstep mode first runs the shift-add multiply in S_MUL and S_CHK,
// and a move or an event that loads the timer runs the divide in S_DIV (DIV_W = bits of
// TIMER_CLOCK_HZ, 24 here). One request at a time: the next is taken right after the previous
// result word is loaded, and S_FIN waits to load it while the sink has not taken an earlier
// word. Reset (rst_ni low, asynchronous) restores the register defaults and stops the motor.
`default_nettype none

module stepper_step_count_controller_unit #(
  parameter int TIMER_CLOCK_HZ = 10000000,
  parameter int COUNT_WIDTH    = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire sscc_pkg::sscc_in_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output sscc_pkg::sscc_out_t                     out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [sscc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sscc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int CW    = COUNT_WIDTH;
  localparam int DIV_W = $clog2(TIMER_CLOCK_HZ + 1);
  localparam logic [31:0] CNT_MASK   = 32'hFFFF_FFFF >> (32 - COUNT_WIDTH);
  localparam logic [31:0] CLK_HZ     = 32'(TIMER_CLOCK_HZ);
  localparam logic [31:0] PERIOD_RST = 32'(TIMER_CLOCK_HZ / 1000);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // Actions taken on the motor state when a request completes.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_HALT  = 3'd1;
  localparam logic [2:0] ACT_START = 3'd2;
  localparam logic [2:0] ACT_STEP  = 3'd3;
  localparam logic [2:0] ACT_LOAD  = 3'd4;

  // Configuration registers.
  logic        motor_en_q, sleep_q, drv_rst_q, dir_q;
  logic [19:0] freq_q;
  logic [31:0] spd_q;
  logic [2:0]  mode_q;

  // Motor state.
  logic [CW-1:0] req_cnt_q, mov_cnt_q;
  logic [19:0]   app_freq_q;
  logic [15:0]   period_q;
  logic          out_on_q, lamp_q;

  // Request in progress.
  logic [2:0]        seq_q, seq_d;
  logic [2:0]        act_q, act_d;
  logic [CW-1:0]     cand_q, cand_d;
  sscc_pkg::sscc_in_t item_q;

  // Output register.
  logic                out_valid_q;
  sscc_pkg::sscc_out_t out_q;

  // Shared unit.
  sscc_pkg::sscc_cmd_t cmd;
  sscc_pkg::sscc_sts_t sts;
  logic [31:0]         op_a, op_b;
  logic [63:0]         unit_res;

  logic          accept;
  logic          commit;
  logic          may_start;
  logic [CW-1:0] left;
  logic [35:0]   scaled;
  logic [CW-1:0] req_n, mov_n;
  logic [19:0]   app_n;
  logic [15:0]   period_n;
  logic          on_n, lamp_n;
  logic          cfg_halt;

  assign in_ready_o = (seq_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (seq_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign may_start  = item_q.limit_ok && motor_en_q && !sleep_q && !drv_rst_q;
  assign left       = req_cnt_q - mov_cnt_q - ONE_C;
  assign scaled     = {4'd0, unit_res[31:0]} << mode_q;
  assign cfg_halt   = cfg_we_i && ((cfg_idx_i == sscc_pkg::CFG_MOTOR_EN) ||
                                   (cfg_idx_i == sscc_pkg::CFG_SLEEP) ||
                                   (cfg_idx_i == sscc_pkg::CFG_DRV_RESET));

  sscc_iter_unit #(
    .DIV_W(DIV_W)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .a_i     (op_a),
    .b_i     (op_b),
    .sts_o   (sts),
    .result_o(unit_res)
  );

  // Sequencer: decodes the request and drives the shared unit.
  always_comb begin
    seq_d     = seq_q;
    act_d     = act_q;
    cand_d    = cand_q;
    cmd.start = 1'b0;
    cmd.op    = sscc_pkg::OP_DIV;
    op_a      = CLK_HZ;
    op_b      = {12'd0, freq_q};
    case (seq_q)
      S_IDLE: begin
        if (accept) begin
          act_d = ACT_NONE;
          seq_d = S_DEC;
        end
      end
      S_DEC: begin
        case (item_q.req_type)
          sscc_pkg::REQ_STEPS: begin
            cand_d = item_q.amount[CW-1:0];
            seq_d  = ((item_q.amount & ~CNT_MASK) == 32'd0) ? S_MOVE : S_FIN;
          end
          sscc_pkg::REQ_DIST: begin
            if (mode_q inside {[3'd0:sscc_pkg::MODE_MAX]}) begin
              cmd.start = 1'b1;
              cmd.op    = sscc_pkg::OP_MUL;
              op_a      = item_q.amount;
              op_b      = spd_q;
              seq_d     = S_MUL;
            end else begin
              cand_d = '0;
              seq_d  = S_MOVE;
            end
          end
          sscc_pkg::REQ_EVENT: begin
            seq_d = S_FIN;
            if (out_on_q) begin
              if (item_q.limit_ok && (left != '0)) begin
                if (app_freq_q == freq_q) begin
                  act_d = ACT_STEP;
                end else if (freq_q == 20'd0) begin
                  act_d = ACT_HALT;
                end else begin
                  act_d     = ACT_LOAD;
                  cmd.start = 1'b1;
                  seq_d     = S_DIV;
                end
              end else begin
                act_d = ACT_HALT;
              end
            end
          end
          default: begin
            seq_d = S_FIN;
          end
        endcase
      end
      S_MUL: begin
        if (sts.done) begin
          seq_d = S_CHK;
        end
      end
      S_CHK: begin
        // Reject a product beyond the count range before or after the microstep shift.
        cand_d = scaled[CW-1:0];
        if ((unit_res > {32'd0, CNT_MASK}) || (scaled > {4'd0, CNT_MASK})) begin
          seq_d = S_FIN;
        end else begin
          seq_d = S_MOVE;
        end
      end
      S_MOVE: begin
        seq_d = S_FIN;
        if (may_start) begin
          if ((cand_q != '0) && (freq_q != 20'd0)) begin
            act_d     = ACT_START;
            cmd.start = 1'b1;
            seq_d     = S_DIV;
          end else begin
            act_d = ACT_HALT;
          end
        end
      end
      S_DIV: begin
        if (sts.done) begin
          seq_d = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          seq_d = S_IDLE;
        end
      end
      default: begin
        seq_d = S_IDLE;
      end
    endcase
  end

  // Motor state after the current request completes.
  always_comb begin
    req_n    = req_cnt_q;
    mov_n    = mov_cnt_q;
    app_n    = app_freq_q;
    period_n = period_q;
    on_n     = out_on_q;
    lamp_n   = lamp_q;
    case (act_q)
      ACT_HALT: begin
        req_n  = '0;
        mov_n  = '0;
        on_n   = 1'b0;
        lamp_n = 1'b0;
      end
      ACT_START: begin
        req_n    = cand_q;
        mov_n    = '0;
        app_n    = freq_q;
        period_n = unit_res[15:0];
        on_n     = 1'b1;
      end
      ACT_STEP: begin
        lamp_n = 1'b1;
        mov_n  = mov_cnt_q + ONE_C;
      end
      ACT_LOAD: begin
        lamp_n   = 1'b1;
        app_n    = freq_q;
        period_n = unit_res[15:0];
        on_n     = 1'b1;
        mov_n    = mov_cnt_q + ONE_C;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= S_IDLE;
      act_q      <= ACT_NONE;
      motor_en_q <= 1'b0;
      sleep_q    <= 1'b0;
      drv_rst_q  <= 1'b0;
      freq_q     <= sscc_pkg::FREQ_RESET;
      spd_q      <= sscc_pkg::SPD_RESET;
      mode_q     <= 3'd0;
      dir_q      <= 1'b0;
    end else begin
      seq_q <= seq_d;
      act_q <= act_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sscc_pkg::CFG_MOTOR_EN:  motor_en_q <= cfg_wdata_i[0];
          sscc_pkg::CFG_SLEEP:     sleep_q    <= cfg_wdata_i[0];
          sscc_pkg::CFG_DRV_RESET: drv_rst_q  <= cfg_wdata_i[0];
          sscc_pkg::CFG_FREQ:      freq_q     <= cfg_wdata_i[19:0];
          sscc_pkg::CFG_SPD:       spd_q      <= cfg_wdata_i;
          sscc_pkg::CFG_MODE:      mode_q     <= cfg_wdata_i[2:0];
          sscc_pkg::CFG_DIR:       dir_q      <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Motor state: updated when a request completes, cleared by a driver control write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_cnt_q  <= '0;
      mov_cnt_q  <= '0;
      app_freq_q <= sscc_pkg::FREQ_RESET;
      period_q   <= PERIOD_RST[15:0];
      out_on_q   <= 1'b0;
      lamp_q     <= 1'b0;
    end else if (commit) begin
      req_cnt_q  <= req_n;
      mov_cnt_q  <= mov_n;
      app_freq_q <= app_n;
      period_q   <= period_n;
      out_on_q   <= on_n;
      lamp_q     <= lamp_n;
    end else if (cfg_halt) begin
      req_cnt_q <= '0;
      mov_cnt_q <= '0;
      out_on_q  <= 1'b0;
      lamp_q    <= 1'b0;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Request capture, candidate count and the result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    cand_q <= cand_d;
    if (commit) begin
      out_q.accepted_steps <= (act_q == ACT_START) ? 32'(cand_q) : 32'd0;
      out_q.timer_period   <= period_n;
      out_q.timer_compare  <= period_n[15:1];
      out_q.pulse_enable   <= on_n;
      out_q.activity_lamp  <= lamp_n;
      out_q.motion_status  <= (req_n != mov_n) ? {1'b0, dir_q} : sscc_pkg::MOTION_STOP;
      out_q.steps_done     <= 32'(mov_n);
      out_q.steps_wanted   <= 32'(req_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/sscc_checker.sv
// Port-level checker for the step count controller, bound to the top level.
`default_nettype none
`include "stepper_step_count_controller_unit_defines.svh"

module sscc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire sscc_pkg::sscc_out_t out_data_o
);

  // A result word waiting for the sink holds its contents.
  `SSCC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // One request at a time: the block stops taking words right after it accepts one.
  `SSCC_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

  // The compare value is always half of the reported period.
  `SSCC_ASSERT_NOW(a_half_duty, out_valid_o,
                   out_data_o.timer_compare == out_data_o.timer_period[15:1])

  // A motor reported as moving has its pulse output on and steps left to go.
  `SSCC_ASSERT_NOW(a_moving_on, out_valid_o && (out_data_o.motion_status != sscc_pkg::MOTION_STOP),
                   out_data_o.pulse_enable &&
                   (out_data_o.steps_done < out_data_o.steps_wanted))

endmodule

bind stepper_step_count_controller_unit sscc_checker u_sscc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
